FILE: rtl/qelu_pkg.sv
`default_nettype none

package qelu_pkg;

   localparam int CORDIC_ITERATIONS = 30;
   localparam int ANG_STEPS_MAX = 40;
   localparam int CORDIC_STEPS =
      (CORDIC_ITERATIONS > ANG_STEPS_MAX) ? ANG_STEPS_MAX : CORDIC_ITERATIONS;

   localparam int SQRT_STEPS = 32;
   localparam int SQRT_PER_STAGE = 2;
   localparam int SQRT_STAGES = (SQRT_STEPS + SQRT_PER_STAGE - 1) / SQRT_PER_STAGE;

   localparam int DIV_STEPS = 33;
   localparam int DIV_PER_STAGE = 2;
   localparam int DIV_STAGES = (DIV_STEPS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;

   localparam int CW = 38;
   localparam int AW = 34;
   localparam int HW = 36;

   localparam logic KIND_EXP = 1'b0;
   localparam logic KIND_LOG = 1'b1;

   localparam logic [30:0] TOL_RESET = 31'd268;

   localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
   localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] SAT_MIN = 32'sh80000000;
   localparam logic signed [HW-1:0] PI_Q30 = 36'sd3373259426;
   localparam logic signed [HW-1:0] TWO_PI_Q30 = 36'sd6746518852;
   localparam logic signed [HW-1:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [CW-1:0] GAIN_Q30 = 38'sd652032874;

   typedef struct packed {
      logic              kind;
      logic signed [31:0] in_w;
      logic signed [31:0] in_x;
      logic signed [31:0] in_y;
      logic signed [31:0] in_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_w;
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
   } rsp_type;

   typedef struct packed {
      logic [63:0] rem;
      logic [63:0] root;
   } sqrt_state_type;

   typedef struct packed {
      logic              kind;
      logic              neg;
      logic              near_zero;
      logic [31:0]       n;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic signed [31:0] vz;
   } aux_type;

   typedef struct packed {
      logic        neg;
      logic        ovf;
      logic [33:0] rem;
      logic [32:0] lo;
   } div_lane_type;

   function automatic logic signed [AW-1:0] atan_q30(input int i);
      logic signed [AW-1:0] r;
      case (i)
         0: r = 34'sd843314856;
         1: r = 34'sd497837829;
         2: r = 34'sd263043836;
         3: r = 34'sd133525158;
         4: r = 34'sd67021686;
         5: r = 34'sd33543515;
         6: r = 34'sd16775850;
         7: r = 34'sd8388437;
         8: r = 34'sd4194282;
         9: r = 34'sd2097149;
         10: r = 34'sd1048575;
         11: r = 34'sd524287;
         12: r = 34'sd262143;
         13: r = 34'sd131071;
         14: r = 34'sd65535;
         15: r = 34'sd32767;
         16: r = 34'sd16383;
         17: r = 34'sd8191;
         18: r = 34'sd4095;
         19: r = 34'sd2047;
         20: r = 34'sd1023;
         21: r = 34'sd511;
         22: r = 34'sd255;
         23: r = 34'sd127;
         24: r = 34'sd63;
         25: r = 34'sd31;
         26: r = 34'sd15;
         27: r = 34'sd7;
         28: r = 34'sd3;
         29: r = 34'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] sat_cw(input logic signed [CW-1:0] v);
      logic signed [31:0] r;
      if (v > CW'(64'sd2147483647)) begin
         r = SAT_MAX;
      end else if (v < -CW'(64'sd2147483648)) begin
         r = SAT_MIN;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] div_result(input div_lane_type l);
      logic signed [31:0] r;
      logic [32:0] nq;
      nq = ~l.lo + 33'd1;
      if (l.ovf) begin
         r = l.neg ? SAT_MIN : SAT_MAX;
      end else if (!l.neg) begin
         r = (l.lo > 33'h07fffffff) ? SAT_MAX : l.lo[31:0];
      end else begin
         r = (l.lo > 33'h080000000) ? SAT_MIN : nq[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/quaternion_exp_log_unit.sv
`default_nettype none

// Channel   Ports                      Direction  Payload
// req       req_valid/req_ready        in         req_data: kind, in_w..in_z
// rsp       rsp_valid/rsp_ready        out        rsp_data: out_w..out_z
// csr       csr_valid/csr_ready        in         csr_data: zero tolerance
//
// One item enters per cycle unless rsp stalls. The pipeline holds the
// 16-stage square root, the CORDIC (one stage per iteration) and the
// 17-stage divider lanes. Synchronous reset clears all valid bits and loads
// the tolerance with its default. A stall on rsp freezes the whole pipeline
// and req_ready drops in the same cycle.
module quaternion_exp_log_unit (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire qelu_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output qelu_pkg::rsp_type     rsp_data,
   input  wire                   csr_valid,
   output logic                  csr_ready,
   input  wire [30:0]            csr_data
);
   import qelu_pkg::*;

   logic adv;
   logic [30:0] tol_ff;

   logic    v0_ff;
   req_type itm0_ff;
   logic    v1_ff;
   req_type itm1_ff;
   logic [63:0] sqx_ff, sqy_ff, sqz_ff;
   logic    v2_ff;
   req_type itm2_ff;
   logic [63:0] sum_ff;

   logic [SQRT_STAGES-1:0] sv_ff;
   sqrt_state_type         sst_ff [SQRT_STAGES];
   req_type                sitm_ff [SQRT_STAGES];

   logic                  csv_ff;
   aux_type               csaux_ff;
   logic signed [CW-1:0]  csx_ff, csy_ff;
   logic signed [AW-1:0]  csa_ff;
   aux_type               csaux_in;
   logic signed [CW-1:0]  csx_in, csy_in;
   logic signed [AW-1:0]  csa_in;

   logic [CORDIC_STEPS-1:0] cv_ff;
   aux_type                 caux_ff [CORDIC_STEPS];
   logic signed [CW-1:0]    cx_ff [CORDIC_STEPS];
   logic signed [CW-1:0]    cy_ff [CORDIC_STEPS];
   logic signed [AW-1:0]    ca_ff [CORDIC_STEPS];

   logic                  mv_ff;
   aux_type               maux_ff;
   logic signed [65:0]    prod_ff [3];
   logic signed [31:0]    mcw_ff;
   logic [32:0]           md_ff;
   logic signed [65:0]    prod_in [3];
   logic signed [31:0]    mcw_in;
   logic [32:0]           md_in;

   logic                  dv0_ff;
   aux_type               daux0_ff;
   div_lane_type          dl0_ff [3];
   logic signed [31:0]    dcw0_ff;
   logic [32:0]           dd0_ff;
   div_lane_type          dl0_in [3];

   logic [DIV_STAGES-1:0] dv_ff;
   aux_type               daux_ff [DIV_STAGES];
   div_lane_type          dl_ff [DIV_STAGES][3];
   logic signed [31:0]    dcw_ff [DIV_STAGES];
   logic [32:0]           dd_ff [DIV_STAGES];

   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_valid && csr_ready) begin
         tol_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         itm0_ff <= req_data;
         itm1_ff <= itm0_ff;
         sqx_ff  <= 64'(itm0_ff.in_x * itm0_ff.in_x);
         sqy_ff  <= 64'(itm0_ff.in_y * itm0_ff.in_y);
         sqz_ff  <= 64'(itm0_ff.in_z * itm0_ff.in_z);
         itm2_ff <= itm1_ff;
         sum_ff  <= sqx_ff + sqy_ff + sqz_ff;
      end
   end

   for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
      sqrt_state_type st_prev, st_in;
      req_type        it_prev;
      logic           v_prev;

      if (g == 0) begin : g_first
         assign st_prev = '{rem: sum_ff, root: 64'd0};
         assign it_prev = itm2_ff;
         assign v_prev  = v2_ff;
      end else begin : g_next
         assign st_prev = sst_ff[g-1];
         assign it_prev = sitm_ff[g-1];
         assign v_prev  = sv_ff[g-1];
      end

      always_comb begin
         logic [63:0] bit_v;
         logic [63:0] trial;
         st_in = st_prev;
         for (int j = 0; j < SQRT_PER_STAGE; j++) begin
            if (g * SQRT_PER_STAGE + j < SQRT_STEPS) begin
               bit_v = 64'd1 << (62 - 2 * (g * SQRT_PER_STAGE + j));
               trial = st_in.root + bit_v;
               if (st_in.rem >= trial) begin
                  st_in.rem  = st_in.rem - trial;
                  st_in.root = (st_in.root >> 1) + bit_v;
               end else begin
                  st_in.root = st_in.root >> 1;
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[g] <= 1'b0;
         end else if (adv) begin
            sv_ff[g] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sst_ff[g]  <= st_in;
            sitm_ff[g] <= it_prev;
         end
      end
   end

   always_comb begin
      logic [31:0]          n;
      logic signed [HW-1:0] h;
      req_type              it;
      it = sitm_ff[SQRT_STAGES-1];
      n  = sst_ff[SQRT_STAGES-1].root[31:0];
      csaux_in.kind = it.kind;
      csaux_in.n    = n;
      csaux_in.vx   = it.in_x;
      csaux_in.vy   = it.in_y;
      csaux_in.vz   = it.in_z;
      csaux_in.neg  = 1'b0;
      h = {3'b000, n, 1'b0};
      if (h > PI_Q30) begin
         h = h - TWO_PI_Q30;
      end
      if (h > HALF_PI_Q30) begin
         h = h - PI_Q30;
         csaux_in.neg = (it.kind == KIND_EXP);
      end else if (h < -HALF_PI_Q30) begin
         h = h + PI_Q30;
         csaux_in.neg = (it.kind == KIND_EXP);
      end
      if (it.kind == KIND_EXP) begin
         csaux_in.near_zero = (n <= {1'b0, tol_ff});
         csx_in = GAIN_Q30;
         csy_in = '0;
         csa_in = h[AW-1:0];
      end else begin
         csaux_in.near_zero = ({1'b0, n} <= {tol_ff, 2'b00});
         if (it.in_w[31]) begin
            csx_in = {6'd0, n};
            csy_in = -{{6{it.in_w[31]}}, it.in_w};
            csa_in = HALF_PI_Q30[AW-1:0];
         end else begin
            csx_in = {{6{it.in_w[31]}}, it.in_w};
            csy_in = {6'd0, n};
            csa_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csv_ff <= 1'b0;
      end else if (adv) begin
         csv_ff <= sv_ff[SQRT_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         csaux_ff <= csaux_in;
         csx_ff   <= csx_in;
         csy_ff   <= csy_in;
         csa_ff   <= csa_in;
      end
   end

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
      aux_type              aux_prev;
      logic signed [CW-1:0] x_prev, y_prev, x_in, y_in;
      logic signed [AW-1:0] a_prev, a_in;
      logic                 v_prev;

      if (g == 0) begin : g_first
         assign aux_prev = csaux_ff;
         assign x_prev   = csx_ff;
         assign y_prev   = csy_ff;
         assign a_prev   = csa_ff;
         assign v_prev   = csv_ff;
      end else begin : g_next
         assign aux_prev = caux_ff[g-1];
         assign x_prev   = cx_ff[g-1];
         assign y_prev   = cy_ff[g-1];
         assign a_prev   = ca_ff[g-1];
         assign v_prev   = cv_ff[g-1];
      end

      always_comb begin
         logic dir_neg;
         dir_neg = (aux_prev.kind == KIND_EXP) ? a_prev[AW-1] : !y_prev[CW-1];
         if (!dir_neg) begin
            x_in = x_prev - (y_prev >>> g);
            y_in = y_prev + (x_prev >>> g);
            a_in = a_prev - atan_q30(g);
         end else begin
            x_in = x_prev + (y_prev >>> g);
            y_in = y_prev - (x_prev >>> g);
            a_in = a_prev + atan_q30(g);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[g] <= 1'b0;
         end else if (adv) begin
            cv_ff[g] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            caux_ff[g] <= aux_prev;
            cx_ff[g]   <= x_in;
            cy_ff[g]   <= y_in;
            ca_ff[g]   <= a_in;
         end
      end
   end

   always_comb begin
      aux_type              aux;
      logic signed [CW-1:0] s_full, c_full;
      logic signed [AW-1:0] mulc;
      aux    = caux_ff[CORDIC_STEPS-1];
      s_full = aux.neg ? -cy_ff[CORDIC_STEPS-1] : cy_ff[CORDIC_STEPS-1];
      c_full = aux.neg ? -cx_ff[CORDIC_STEPS-1] : cx_ff[CORDIC_STEPS-1];
      mulc   = (aux.kind == KIND_EXP) ? s_full[AW-1:0] : ca_ff[CORDIC_STEPS-1];
      prod_in[0] = 66'(mulc * aux.vx);
      prod_in[1] = 66'(mulc * aux.vy);
      prod_in[2] = 66'(mulc * aux.vz);
      mcw_in = sat_cw(c_full);
      md_in  = (aux.kind == KIND_EXP) ? {1'b0, aux.n} : {aux.n, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mv_ff <= 1'b0;
      end else if (adv) begin
         mv_ff <= cv_ff[CORDIC_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         maux_ff <= caux_ff[CORDIC_STEPS-1];
         prod_ff <= prod_in;
         mcw_ff  <= mcw_in;
         md_ff   <= md_in;
      end
   end

   always_comb begin
      logic [65:0] mag;
      for (int l = 0; l < 3; l++) begin
         mag = prod_ff[l][65] ? 66'(-prod_ff[l]) : prod_ff[l];
         dl0_in[l].neg = prod_ff[l][65];
         dl0_in[l].ovf = ({2'b00, mag[63:33]} >= md_ff);
         dl0_in[l].rem = {3'b000, mag[63:33]};
         dl0_in[l].lo  = mag[32:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv0_ff <= 1'b0;
      end else if (adv) begin
         dv0_ff <= mv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         daux0_ff <= maux_ff;
         dl0_ff   <= dl0_in;
         dcw0_ff  <= mcw_ff;
         dd0_ff   <= md_ff;
      end
   end

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      aux_type            aux_prev;
      div_lane_type       l_prev [3];
      div_lane_type       l_in [3];
      logic signed [31:0] cw_prev;
      logic [32:0]        d_prev;
      logic               v_prev;

      if (g == 0) begin : g_first
         assign aux_prev = daux0_ff;
         assign l_prev   = dl0_ff;
         assign cw_prev  = dcw0_ff;
         assign d_prev   = dd0_ff;
         assign v_prev   = dv0_ff;
      end else begin : g_next
         assign aux_prev = daux_ff[g-1];
         assign l_prev   = dl_ff[g-1];
         assign cw_prev  = dcw_ff[g-1];
         assign d_prev   = dd_ff[g-1];
         assign v_prev   = dv_ff[g-1];
      end

      always_comb begin
         logic [33:0] r;
         l_in = l_prev;
         for (int j = 0; j < DIV_PER_STAGE; j++) begin
            if (g * DIV_PER_STAGE + j < DIV_STEPS) begin
               for (int l = 0; l < 3; l++) begin
                  r = {l_in[l].rem[32:0], l_in[l].lo[32]};
                  l_in[l].lo = {l_in[l].lo[31:0], 1'b0};
                  if (r >= {1'b0, d_prev}) begin
                     r = r - {1'b0, d_prev};
                     l_in[l].lo[0] = 1'b1;
                  end
                  l_in[l].rem = r;
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[g] <= 1'b0;
         end else if (adv) begin
            dv_ff[g] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            daux_ff[g] <= aux_prev;
            dl_ff[g]   <= l_in;
            dcw_ff[g]  <= cw_prev;
            dd_ff[g]   <= d_prev;
         end
      end
   end

   always_comb begin
      aux_type aux;
      aux = daux_ff[DIV_STAGES-1];
      if (aux.near_zero) begin
         rsp_in.out_w = (aux.kind == KIND_EXP) ? ONE_Q30 : '0;
         rsp_in.out_x = '0;
         rsp_in.out_y = '0;
         rsp_in.out_z = '0;
      end else begin
         rsp_in.out_w = (aux.kind == KIND_EXP) ? dcw_ff[DIV_STAGES-1] : '0;
         rsp_in.out_x = div_result(dl_ff[DIV_STAGES-1][0]);
         rsp_in.out_y = div_result(dl_ff[DIV_STAGES-1][1]);
         rsp_in.out_z = div_result(dl_ff[DIV_STAGES-1][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_ff[DIV_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef SYNTHESIS
   a_small_exp_identity: assert property (@(posedge clock) disable iff (reset)
      adv && dv_ff[DIV_STAGES-1] && daux_ff[DIV_STAGES-1].near_zero &&
      daux_ff[DIV_STAGES-1].kind == KIND_EXP
      |=> rsp_data.out_w == ONE_Q30 && rsp_data.out_x == '0 &&
          rsp_data.out_y == '0 && rsp_data.out_z == '0)
      else $error("identity result expected for small rotation vector");

   a_log_scalar_zero: assert property (@(posedge clock) disable iff (reset)
      adv && dv_ff[DIV_STAGES-1] && daux_ff[DIV_STAGES-1].kind == KIND_LOG
      |=> rsp_data.out_w == '0)
      else $error("logarithm result carries a nonzero scalar part");

   a_stall_freezes_cordic: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(cv_ff) && $stable(sv_ff) && $stable(dv_ff))
      else $error("pipeline valid bits moved during a stall");
`endif

endmodule

`default_nettype wire

FILE: bench/quaternion_exp_log_unit_tb.sv
`timescale 1ns / 100ps

module quaternion_exp_log_unit_tb;
   import qelu_pkg::*;

   localparam int LATENCY = 80;
   localparam int CYCLE_LIMIT = 600000;

   class qmap_scoreboard;
      logic [30:0] tolerance;
      rsp_type pending[$];
      int mismatches;
      int orphans;
      int checked;
      longint atan_tab[40] = '{
         843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
         16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
         65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31, 15,
         7, 3, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};

      function new();
         tolerance = TOL_RESET;
         mismatches = 0;
         orphans = 0;
         checked = 0;
      endfunction

      function logic signed [31:0] clamp32(longint v);
         if (v > 64'sd2147483647) return 32'sh7fffffff;
         if (v < -64'sd2147483648) return 32'sh80000000;
         return v[31:0];
      endfunction

      function longint vec_norm(longint x, longint y, longint z);
         longint unsigned s, r, b;
         s = longint'(x * x) + longint'(y * y) + longint'(z * z);
         r = 0;
         b = 64'd1 << 62;
         for (int k = 0; k < 32; k++) begin
            if (s >= r + b) begin
               s = s - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return longint'(r);
      endfunction

      function rsp_type map_item(req_type q);
         rsp_type o;
         longint v[3], w, n, h, a, cx, sy, nx;
         longint half_pi, pi_v;
         bit neg;
         half_pi = 64'sd1686629713;
         pi_v = 64'sd3373259426;
         w = q.in_w;
         v[0] = q.in_x;
         v[1] = q.in_y;
         v[2] = q.in_z;
         n = vec_norm(v[0], v[1], v[2]);
         o = '0;
         neg = 0;
         if (q.kind == KIND_EXP) begin
            if (n <= longint'(tolerance)) begin
               o.out_w = ONE_Q30;
               return o;
            end
            h = n * 2;
            if (h > pi_v) h = h - 64'sd6746518852;
            if (h > half_pi) begin
               h = h - pi_v;
               neg = 1;
            end else if (h < -half_pi) begin
               h = h + pi_v;
               neg = 1;
            end
            cx = 64'sd652032874;
            sy = 0;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
               if (h >= 0) begin
                  nx = cx - (sy >>> i);
                  sy = sy + (cx >>> i);
                  h = h - atan_tab[i];
               end else begin
                  nx = cx + (sy >>> i);
                  sy = sy - (cx >>> i);
                  h = h + atan_tab[i];
               end
               cx = nx;
            end
            if (neg) begin
               cx = -cx;
               sy = -sy;
            end
            o.out_w = clamp32(cx);
            o.out_x = clamp32((v[0] * sy) / n);
            o.out_y = clamp32((v[1] * sy) / n);
            o.out_z = clamp32((v[2] * sy) / n);
            return o;
         end
         if (n <= longint'(tolerance) * 4) return o;
         cx = w;
         sy = n;
         a = 0;
         if (cx < 0) begin
            cx = n;
            sy = -w;
            a = half_pi;
         end
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (sy >= 0) begin
               nx = cx + (sy >>> i);
               sy = sy - (cx >>> i);
               a = a + atan_tab[i];
            end else begin
               nx = cx - (sy >>> i);
               sy = sy + (cx >>> i);
               a = a - atan_tab[i];
            end
            cx = nx;
         end
         o.out_x = clamp32((a * v[0]) / (2 * n));
         o.out_y = clamp32((a * v[1]) / (2 * n));
         o.out_z = clamp32((a * v[2]) / (2 * n));
         return o;
      endfunction

      function void note_request(req_type q);
         pending.push_back(map_item(q));
      endfunction

      function void check_response(rsp_type r);
         rsp_type e;
         if (pending.size() == 0) begin
            orphans++;
            if (orphans + mismatches <= 10)
               $display("Unexpected result %h with nothing pending", r);
            return;
         end
         e = pending.pop_front();
         checked++;
         if (r !== e) begin
            mismatches++;
            if (orphans + mismatches <= 10)
               $display("Mismatch: expected w=%0d x=%0d y=%0d z=%0d, got w=%0d x=%0d y=%0d z=%0d",
                        e.out_w, e.out_x, e.out_y, e.out_z,
                        r.out_w, r.out_x, r.out_y, r.out_z);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [30:0] csr_data;

   qmap_scoreboard board;
   int cycles = 0;
   bit send_quiet;
   bit recv_quiet;
   int sent;

   quaternion_exp_log_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial board = new();

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Run exceeded its cycle limit with %0d results pending",
                  board.pending.size());
         $display("[quaternion_exp_log_unit] ERROR");
         $finish;
      end
      if (!reset) begin
         if (req_valid && req_ready) board.note_request(req_data);
         if (rsp_valid && rsp_ready) board.check_response(rsp_data);
      end
   end

   initial begin
      int gap;
      rsp_ready = 0;
      @(negedge reset);
      forever begin
         gap = recv_quiet ? 0 : $urandom_range(0, 11);
         repeat (gap) begin
            @(negedge clock);
            rsp_ready <= 0;
         end
         @(negedge clock);
         rsp_ready <= 1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   task automatic send_item(req_type q);
      int gap;
      gap = send_quiet ? 0 : $urandom_range(0, 11);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 0;
      end
      @(negedge clock);
      req_valid <= 1;
      req_data <= q;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic write_tolerance(logic [30:0] value);
      drain();
      @(negedge clock);
      csr_valid <= 1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.tolerance = value;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   function automatic req_type make_item(logic kind, int w, int x, int y, int z);
      req_type q;
      q.kind = kind;
      q.in_w = w;
      q.in_x = x;
      q.in_y = y;
      q.in_z = z;
      return q;
   endfunction

   function automatic int near_value(int span);
      int m;
      m = $urandom_range(0, span);
      return $urandom_range(0, 1) ? m : -m;
   endfunction

   function automatic req_type random_item();
      req_type q;
      int mode;
      int t;
      mode = $urandom_range(0, 9);
      q.kind = 1'($urandom_range(0, 1));
      q.in_w = $urandom;
      q.in_x = $urandom;
      q.in_y = $urandom;
      q.in_z = $urandom;
      t = int'(board.tolerance);
      if (mode >= 6 && mode <= 7) begin
         if (t > 2000000 || t < 0) t = 2000;
         q.in_x = near_value(4 * t + 8);
         q.in_y = near_value(4 * t + 8);
         q.in_z = near_value(4 * t + 8);
      end else if (mode == 8) begin
         q.in_y = 0;
         q.in_z = 0;
      end else if (mode == 9) begin
         q.in_w = near_value(1 << 30);
         q.in_x = near_value(1 << 29);
         q.in_y = near_value(1 << 29);
         q.in_z = near_value(1 << 29);
      end
      return q;
   endfunction

   initial begin
      logic [30:0] settings[5];
      req_type directed[$];
      int max_i;
      int min_i;
      max_i = 32'h7fffffff;
      min_i = 32'h80000000;
      sent = 0;
      send_quiet = 0;
      recv_quiet = 0;
      reset = 1;
      req_valid = 0;
      req_data = '0;
      csr_valid = 0;
      csr_data = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      directed.push_back(make_item(KIND_EXP, 0, 0, 0, 0));
      directed.push_back(make_item(KIND_EXP, max_i, 268, 0, 0));
      directed.push_back(make_item(KIND_EXP, 0, 269, 0, 0));
      directed.push_back(make_item(KIND_EXP, 0, max_i, max_i, max_i));
      directed.push_back(make_item(KIND_EXP, 0, min_i, min_i, min_i));
      directed.push_back(make_item(KIND_EXP, 0, min_i, max_i, 0));
      directed.push_back(make_item(KIND_EXP, 0, 843314857, 0, 0));
      directed.push_back(make_item(KIND_EXP, 0, 1686629713, 0, 0));
      directed.push_back(make_item(KIND_EXP, 0, 1686629714, 0, 0));
      directed.push_back(make_item(KIND_EXP, 0, 0, -1000000000, 0));
      directed.push_back(make_item(KIND_EXP, 0, 0, 0, 1));
      directed.push_back(make_item(KIND_LOG, 1 << 30, 0, 0, 0));
      directed.push_back(make_item(KIND_LOG, 0, 1072, 0, 0));
      directed.push_back(make_item(KIND_LOG, 0, 1073, 0, 0));
      directed.push_back(make_item(KIND_LOG, 0, 1 << 30, 0, 0));
      directed.push_back(make_item(KIND_LOG, -(1 << 30) + 100, 0, 0, 46000));
      directed.push_back(make_item(KIND_LOG, min_i, 0, 0, 100000));
      directed.push_back(make_item(KIND_LOG, max_i, max_i, max_i, max_i));
      directed.push_back(make_item(KIND_LOG, min_i, min_i, min_i, min_i));
      directed.push_back(make_item(KIND_LOG, -759250125, 759250125, 0, 0));
      directed.push_back(make_item(KIND_LOG, 759250125, 0, -759250125, 0));
      directed.push_back(make_item(KIND_LOG, 1, min_i, 1, max_i));
      foreach (directed[i]) send_item(directed[i]);
      drain();

      settings[0] = 31'd0;
      settings[1] = 31'h7fffffff;
      settings[2] = 31'($urandom_range(1, 1 << 20));
      settings[3] = 31'($urandom);
      settings[4] = TOL_RESET;
      foreach (settings[p]) begin
         write_tolerance(settings[p]);
         for (int k = 0; k < 340; k++) begin
            if (k % 60 == 0) begin
               send_quiet = $urandom_range(0, 3) == 0;
               recv_quiet = $urandom_range(0, 3) == 0;
            end
            if (k == 170) begin
               @(negedge clock);
               req_valid <= 0;
               while (board.pending.size() != 0) @(posedge clock);
            end
            send_item(random_item());
         end
      end

      drain();
      $display("Covered %0d items over five tolerance settings, including zero and full scale,",
               sent);
      $display("with %0d results checked, %0d mismatches and %0d unexpected results.",
               board.checked, board.mismatches, board.orphans);
      if (board.mismatches == 0 && board.orphans == 0 && board.pending.size() == 0) begin
         $display("[quaternion_exp_log_unit] OK");
      end else begin
         $display("[quaternion_exp_log_unit] ERROR");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/qelu_pkg.sv
rtl/quaternion_exp_log_unit.sv
bench/quaternion_exp_log_unit_tb.sv
